### rtl/core/cgtc_pkg.sv
package cgtc_pkg;

   localparam int STAGES = 6;

   localparam longint unsigned US_PER_MIN  = 64'd60000000;
   localparam longint unsigned US_PER_HOUR = 64'd3600000000;
   localparam longint unsigned US_PER_DAY  = 64'd86400000000;

   // calendar to mjd: mjd = 365.25*y + 30.6001*(m+1) + day - CAL_MJD_OFFSET
   localparam longint unsigned CAL_MJD_OFFSET = 64'd679019;
   localparam longint unsigned GPS_EPOCH_MJD  = 64'd44244;

   // gps to calendar: b = mjd + 2401538, n = 100*b - 12210
   localparam longint unsigned B_BASE    = GPS_EPOCH_MJD + 64'd2401538;
   localparam longint unsigned CENT_BASE = 64'd100 * B_BASE - 64'd12210;
   localparam longint unsigned YEAR_BASE = 64'd4715;

   // reciprocal constants, exact floor for the operand widths used
   localparam int              WEEK_SHIFT  = 23;
   localparam longint unsigned WEEK_RECIP  = ((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7;

   localparam longint unsigned DAY_DIV     = US_PER_DAY >> 13;
   localparam int              DAY_SHIFT   = 51;
   localparam longint unsigned DAY_RECIP   =
      ((64'd1 << DAY_SHIFT) + DAY_DIV - 64'd1) / DAY_DIV;

   localparam longint unsigned CENT_DIV    = 64'd36525;
   localparam int              CENT_SHIFT  = 44;
   localparam longint unsigned CENT_RECIP  =
      ((64'd1 << CENT_SHIFT) + CENT_DIV - 64'd1) / CENT_DIV;

   localparam longint unsigned MIN_DIV     = US_PER_MIN >> 8;
   localparam int              MIN_SHIFT   = 47;
   localparam longint unsigned MIN_RECIP   =
      ((64'd1 << MIN_SHIFT) + MIN_DIV - 64'd1) / MIN_DIV;

   localparam int              HOUR_SHIFT  = 17;
   localparam longint unsigned HOUR_RECIP  = ((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60;

   localparam longint unsigned MONTH_DIV   = 64'd306001;
   localparam int              MONTH_SHIFT = 29;
   localparam longint unsigned MONTH_RECIP =
      ((64'd10000 << MONTH_SHIFT) + MONTH_DIV - 64'd1) / MONTH_DIV;

   typedef enum logic {
      OP_CAL_TO_GPS = 1'b0,
      OP_GPS_TO_CAL = 1'b1
   } op_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [25:0] second_us;
   } cal_time_type;

   typedef struct packed {
      logic [12:0] week;
      logic [39:0] week_seconds_us;
   } gps_time_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_ctl_type;

   // floor(30.6001 * (m + 1)) with the month shifted as the day count needs
   function automatic logic [8:0] month_term(input logic [3:0] month);
      logic [8:0] r;
      unique case (month)
         4'd0:  r = 9'd397;
         4'd1:  r = 9'd428;
         4'd2:  r = 9'd459;
         4'd3:  r = 9'd122;
         4'd4:  r = 9'd153;
         4'd5:  r = 9'd183;
         4'd6:  r = 9'd214;
         4'd7:  r = 9'd244;
         4'd8:  r = 9'd275;
         4'd9:  r = 9'd306;
         4'd10: r = 9'd336;
         4'd11: r = 9'd367;
         4'd12: r = 9'd397;
         4'd13: r = 9'd428;
         4'd14: r = 9'd459;
         4'd15: r = 9'd489;
      endcase
      return r;
   endfunction

   // floor(30.6001 * e)
   function automatic logic [8:0] date_term(input logic [3:0] e);
      logic [8:0] r;
      unique case (e)
         4'd0:  r = 9'd0;
         4'd1:  r = 9'd30;
         4'd2:  r = 9'd61;
         4'd3:  r = 9'd91;
         4'd4:  r = 9'd122;
         4'd5:  r = 9'd153;
         4'd6:  r = 9'd183;
         4'd7:  r = 9'd214;
         4'd8:  r = 9'd244;
         4'd9:  r = 9'd275;
         4'd10: r = 9'd306;
         4'd11: r = 9'd336;
         4'd12: r = 9'd367;
         4'd13: r = 9'd397;
         4'd14: r = 9'd428;
         4'd15: r = 9'd459;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] month_of(input logic [3:0] e);
      logic [3:0] r;
      if (e >= 4'd14) begin
         r = e - 4'd13;
      end else begin
         r = e - 4'd1;
      end
      return r;
   endfunction

   // one when the month is march or later, which takes one more off the year
   function automatic logic year_step(input logic [3:0] e);
      return (e >= 4'd4) && (e <= 4'd13);
   endfunction

endpackage

### rtl/core/calendar_gps_time_converter_unit.sv
// channel   direction  handshake              word
// req_      in         req_valid / req_ready  operation, calendar and gps fields
// rsp_      out        rsp_valid / rsp_ready  calendar, gps fields, before_epoch
//
// six register stages, one word accepted per cycle while the output is not stalled
// the divisions are done as reciprocal multiplies spread over the stages
// reset clears the stage valid bits only
// each stage holds its word only while the next one is full and stalled,
// so empty stages still fill while the output waits
module calendar_gps_time_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [11:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [25:0] req_in_second_us,
   input  logic [12:0] req_in_week,
   input  logic [39:0] req_in_week_seconds_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [25:0] rsp_out_second_us,
   output logic [12:0] rsp_out_week,
   output logic [39:0] rsp_out_week_seconds_us,
   output logic        rsp_before_epoch
);

   logic [cgtc_pkg::STAGES-1:0]   valid_in, valid_ff;
   logic [cgtc_pkg::STAGES-1:0]   stage_ready;
   logic [cgtc_pkg::STAGES-1:0]   load;
   logic [cgtc_pkg::STAGES-2:0]   op_ff;

   cgtc_pkg::stage_ctl_type ctl;
   cgtc_pkg::cal_time_type  cal_req, cal_rsp, cal_out_in, cal_out_ff;
   cgtc_pkg::gps_time_type  gps_req, gps_rsp, gps_out_in, gps_out_ff;
   logic                    c2g_before;
   logic                    before_in, before_ff;

   assign cal_req.year      = req_in_year;
   assign cal_req.month     = req_in_month;
   assign cal_req.day       = req_in_day;
   assign cal_req.hour      = req_in_hour;
   assign cal_req.minute    = req_in_minute;
   assign cal_req.second_us = req_in_second_us;

   assign gps_req.week            = req_in_week;
   assign gps_req.week_seconds_us = req_in_week_seconds_us;

   // ready chain from the output back to the input
   always_comb begin
      stage_ready[cgtc_pkg::STAGES-1] = !valid_ff[cgtc_pkg::STAGES-1] || rsp_ready;
      for (int i = cgtc_pkg::STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      load[0]     = stage_ready[0] && req_valid;
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < cgtc_pkg::STAGES; i++) begin
         load[i]     = stage_ready[i] && valid_ff[i-1];
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign ctl.s1 = load[0];
   assign ctl.s2 = load[1];
   assign ctl.s3 = load[2];
   assign ctl.s4 = load[3];
   assign ctl.s5 = load[4];

   cgtc_c2g u_c2g (
      .clock        (clock),
      .ctl          (ctl),
      .cal          (cal_req),
      .gps          (gps_rsp),
      .before_epoch (c2g_before)
   );

   cgtc_g2c u_g2c (
      .clock (clock),
      .ctl   (ctl),
      .gps   (gps_req),
      .cal   (cal_rsp)
   );

   // output select, the unused direction reads as zero
   always_comb begin
      cal_out_in = '0;
      gps_out_in = '0;
      before_in  = 1'b0;
      if (op_ff[cgtc_pkg::STAGES-2] == cgtc_pkg::OP_GPS_TO_CAL) begin
         cal_out_in = cal_rsp;
      end else begin
         before_in = c2g_before;
         if (!c2g_before) begin
            gps_out_in = gps_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load[0]) begin
         op_ff[0] <= req_operation;
      end
      for (int i = 1; i < cgtc_pkg::STAGES - 1; i++) begin
         if (load[i]) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
      if (load[cgtc_pkg::STAGES-1]) begin
         cal_out_ff <= cal_out_in;
         gps_out_ff <= gps_out_in;
         before_ff  <= before_in;
      end
   end

   assign req_ready               = stage_ready[0];
   assign rsp_valid               = valid_ff[cgtc_pkg::STAGES-1];
   assign rsp_out_year            = cal_out_ff.year;
   assign rsp_out_month           = cal_out_ff.month;
   assign rsp_out_day             = cal_out_ff.day;
   assign rsp_out_hour            = cal_out_ff.hour;
   assign rsp_out_minute          = cal_out_ff.minute;
   assign rsp_out_second_us       = cal_out_ff.second_us;
   assign rsp_out_week            = gps_out_ff.week;
   assign rsp_out_week_seconds_us = gps_out_ff.week_seconds_us;
   assign rsp_before_epoch        = before_ff;

endmodule

### rtl/core/cgtc_c2g.sv
module cgtc_c2g (
   input  logic                   clock,
   input  cgtc_pkg::stage_ctl_type ctl,
   input  cgtc_pkg::cal_time_type  cal,
   output cgtc_pkg::gps_time_type  gps,
   output logic                   before_epoch
);

   logic               early_month;
   logic [11:0]        year_adj;
   logic signed [21:0] ypart_in, ypart_ff;
   logic [8:0]         mterm_in, mterm_ff;
   logic [4:0]         day_ff;
   logic [36:0]        tod1_in, tod1_ff;

   logic               day_carry;
   logic signed [21:0] mjd;
   logic [36:0]        tod2_in, tod2_ff;
   logic               before2_in, before2_ff;
   logic [19:0]        rel_in, rel_ff;

   logic [40:0]        week_prod;
   logic [12:0]        week3_in, week3_ff;
   logic [2:0]         rel3_ff;
   logic [36:0]        tod3_ff;
   logic               before3_ff;

   logic [2:0]         rem_in, rem_ff;
   logic [12:0]        week4_ff;
   logic [36:0]        tod4_ff;
   logic               before4_ff;

   logic [39:0]        sow_in, sow_ff;
   logic [12:0]        week5_ff;
   logic               before5_ff;

   // stage 1: year and month terms, time of day in microseconds
   always_comb begin
      early_month = (cal.month <= 4'd2);
      year_adj    = early_month ? cal.year - 12'd1 : cal.year;
      if (early_month && (cal.year == 12'd0)) begin
         ypart_in = -22'sd365;
      end else begin
         ypart_in = $signed(22'(year_adj) * 22'd365 + 22'(year_adj[11:2]));
      end
      mterm_in = cgtc_pkg::month_term(cal.month);
      tod1_in  = 37'(cal.hour) * 37'(cgtc_pkg::US_PER_HOUR)
               + 37'(cal.minute) * 37'(cgtc_pkg::US_PER_MIN)
               + 37'(cal.second_us);
   end

   // stage 2: day carry, mjd and offset from epoch
   always_comb begin
      day_carry  = (tod1_ff >= 37'(cgtc_pkg::US_PER_DAY));
      tod2_in    = day_carry ? tod1_ff - 37'(cgtc_pkg::US_PER_DAY) : tod1_ff;
      mjd        = ypart_ff + $signed({13'd0, mterm_ff}) + $signed({17'd0, day_ff})
                 + $signed({21'd0, day_carry})
                 - $signed(22'(cgtc_pkg::CAL_MJD_OFFSET));
      before2_in = (mjd < $signed(22'(cgtc_pkg::GPS_EPOCH_MJD)));
      rel_in     = 20'(mjd - $signed(22'(cgtc_pkg::GPS_EPOCH_MJD)));
   end

   // stage 3: week by reciprocal of seven
   always_comb begin
      week_prod = 41'(rel_ff) * 41'(cgtc_pkg::WEEK_RECIP);
      week3_in  = week_prod[cgtc_pkg::WEEK_SHIFT+12:cgtc_pkg::WEEK_SHIFT];
   end

   // stage 4: day of week, rel - 7*week taken modulo 8
   assign rem_in = rel3_ff + week3_ff[2:0];

   // stage 5: seconds of week
   assign sow_in = 40'(rem_ff) * 40'(cgtc_pkg::US_PER_DAY) + 40'(tod4_ff);

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         ypart_ff <= ypart_in;
         mterm_ff <= mterm_in;
         day_ff   <= cal.day;
         tod1_ff  <= tod1_in;
      end
      if (ctl.s2) begin
         tod2_ff    <= tod2_in;
         before2_ff <= before2_in;
         rel_ff     <= rel_in;
      end
      if (ctl.s3) begin
         week3_ff   <= week3_in;
         rel3_ff    <= rel_ff[2:0];
         tod3_ff    <= tod2_ff;
         before3_ff <= before2_ff;
      end
      if (ctl.s4) begin
         rem_ff     <= rem_in;
         week4_ff   <= week3_ff;
         tod4_ff    <= tod3_ff;
         before4_ff <= before3_ff;
      end
      if (ctl.s5) begin
         sow_ff     <= sow_in;
         week5_ff   <= week4_ff;
         before5_ff <= before4_ff;
      end
   end

   assign gps.week            = week5_ff;
   assign gps.week_seconds_us = sow_ff;
   assign before_epoch        = before5_ff;

endmodule

### rtl/core/cgtc_g2c.sv
module cgtc_g2c (
   input  logic                   clock,
   input  cgtc_pkg::stage_ctl_type ctl,
   input  cgtc_pkg::gps_time_type  gps,
   output cgtc_pkg::cal_time_type  cal
);

   logic [54:0] day_prod;
   logic [3:0]  dq_in, dq_ff;
   logic [39:0] sow1_ff;
   logic [12:0] week1_ff;

   logic [36:0] tod2_in, tod2_ff;
   logic [27:0] cn_in, cn_ff;
   logic [21:0] cb_in, cb_ff;

   logic [56:0] cent_prod;
   logic [58:0] min_prod;
   logic [12:0] c3_in, c3_ff;
   logic [10:0] mod3_in, mod3_ff;
   logic [21:0] b3_ff;
   logic [36:0] tod3_ff;

   logic [21:0] dpart;
   logic [22:0] hour_prod;
   logic [9:0]  x4_in, x4_ff;
   logic [25:0] sec4_in, sec4_ff;
   logic [4:0]  hr4_in, hr4_ff;
   logic [12:0] c4_ff;
   logic [10:0] mod4_ff;

   logic [34:0] month_prod;
   logic [3:0]  e5_in, e5_ff;
   logic [5:0]  min5_in, min5_ff;
   logic [9:0]  x5_ff;
   logic [12:0] c5_ff;
   logic [25:0] sec5_ff;
   logic [4:0]  hr5_ff;

   // stage 1: whole days in seconds of week
   always_comb begin
      day_prod = 55'(gps.week_seconds_us[39:13]) * 55'(cgtc_pkg::DAY_RECIP);
      dq_in    = day_prod[cgtc_pkg::DAY_SHIFT+3:cgtc_pkg::DAY_SHIFT];
   end

   // stage 2: time of day and the day-number sums
   always_comb begin
      tod2_in = 37'(sow1_ff - 40'(dq_ff) * 40'(cgtc_pkg::US_PER_DAY));
      cn_in   = 28'(30'(week1_ff) * 30'd700 + 30'(dq_ff) * 30'd100
                    + 30'(cgtc_pkg::CENT_BASE));
      cb_in   = 22'(week1_ff) * 22'd7 + 22'(dq_ff) + 22'(cgtc_pkg::B_BASE);
   end

   // stage 3: julian century count and minute of day
   always_comb begin
      cent_prod = 57'(cn_ff) * 57'(cgtc_pkg::CENT_RECIP);
      c3_in     = cent_prod[cgtc_pkg::CENT_SHIFT+12:cgtc_pkg::CENT_SHIFT];
      min_prod  = 59'(tod2_ff[36:8]) * 59'(cgtc_pkg::MIN_RECIP);
      mod3_in   = min_prod[cgtc_pkg::MIN_SHIFT+10:cgtc_pkg::MIN_SHIFT];
   end

   // stage 4: day within the shifted year, seconds and hour
   always_comb begin
      dpart     = 22'(c3_ff) * 22'd365 + 22'(c3_ff[12:2]);
      x4_in     = 10'(b3_ff - dpart);
      sec4_in   = 26'(tod3_ff - 37'(mod3_ff) * 37'(cgtc_pkg::US_PER_MIN));
      hour_prod = 23'(mod3_ff) * 23'(cgtc_pkg::HOUR_RECIP);
      hr4_in    = hour_prod[cgtc_pkg::HOUR_SHIFT+4:cgtc_pkg::HOUR_SHIFT];
   end

   // stage 5: month index and minute
   always_comb begin
      month_prod = 35'(x4_ff) * 35'(cgtc_pkg::MONTH_RECIP);
      e5_in      = month_prod[cgtc_pkg::MONTH_SHIFT+3:cgtc_pkg::MONTH_SHIFT];
      min5_in    = 6'(mod4_ff - 11'(hr4_ff) * 11'd60);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         dq_ff    <= dq_in;
         sow1_ff  <= gps.week_seconds_us;
         week1_ff <= gps.week;
      end
      if (ctl.s2) begin
         tod2_ff <= tod2_in;
         cn_ff   <= cn_in;
         cb_ff   <= cb_in;
      end
      if (ctl.s3) begin
         c3_ff   <= c3_in;
         mod3_ff <= mod3_in;
         b3_ff   <= cb_ff;
         tod3_ff <= tod2_ff;
      end
      if (ctl.s4) begin
         x4_ff   <= x4_in;
         sec4_ff <= sec4_in;
         hr4_ff  <= hr4_in;
         c4_ff   <= c3_ff;
         mod4_ff <= mod3_ff;
      end
      if (ctl.s5) begin
         e5_ff   <= e5_in;
         min5_ff <= min5_in;
         x5_ff   <= x4_ff;
         c5_ff   <= c4_ff;
         sec5_ff <= sec4_ff;
         hr5_ff  <= hr4_ff;
      end
   end

   always_comb begin
      cal.year      = 12'(c5_ff - 13'(cgtc_pkg::YEAR_BASE)
                          - 13'(cgtc_pkg::year_step(e5_ff)));
      cal.month     = cgtc_pkg::month_of(e5_ff);
      cal.day       = 5'(x5_ff - 10'(cgtc_pkg::date_term(e5_ff)));
      cal.hour      = hr5_ff;
      cal.minute    = min5_ff;
      cal.second_us = sec5_ff;
   end

endmodule

### sim/calendar_gps_time_converter_unit_tb.sv
module calendar_gps_time_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1050;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      cgtc_pkg::op_type op;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [25:0] second_us;
      logic [12:0] week;
      logic [39:0] week_sec_us;
   } conv_request_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [25:0] second_us;
      logic [12:0] week;
      logic [39:0] week_sec_us;
      logic        before_epoch;
   } conv_result_type;

   class time_conversion_scoreboard;
      localparam longint MIN_US   = 64'sd60000000;
      localparam longint HOUR_US  = 64'sd3600000000;
      localparam longint DAY_US   = 64'sd86400000000;
      localparam longint EPOCH_MJ = 64'sd44244;

      conv_result_type expected_times[$];
      int errors = 0;
      int cal_count = 0;
      int gps_count = 0;
      int before_count = 0;
      int checked = 0;

      function conv_result_type convert_time(conv_request_type w);
         conv_result_type r;
         longint y, m, mjd, tod, rel, wk, sow;
         longint b, c, d, e, dd, mo, yr;
         r = '0;
         if (w.op == cgtc_pkg::OP_CAL_TO_GPS) begin
            if (w.month <= 4'd2) begin
               y = longint'(w.year) - 1;
               m = longint'(w.month) + 12;
            end else begin
               y = longint'(w.year);
               m = longint'(w.month);
            end
            // signed division truncates toward zero
            mjd = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + longint'(w.day) - 679019;
            tod = longint'(w.hour) * HOUR_US + longint'(w.minute) * MIN_US
                  + longint'(w.second_us);
            mjd = mjd + tod / DAY_US;
            tod = tod % DAY_US;
            if (mjd < EPOCH_MJ) begin
               r.before_epoch = 1'b1;
            end else begin
               rel = mjd - EPOCH_MJ;
               wk  = rel / 7;
               sow = (rel % 7) * DAY_US + tod;
               r.week        = wk[12:0];
               r.week_sec_us = sow[39:0];
            end
         end else begin
            sow = longint'(w.week_sec_us);
            mjd = EPOCH_MJ + longint'(w.week) * 7 + sow / DAY_US;
            tod = sow % DAY_US;
            b   = mjd + 2400001 + 1537;
            c   = (100 * b - 12210) / 36525;
            d   = (1461 * c) / 4;
            e   = (10000 * (b - d)) / 306001;
            dd  = b - d - (306001 * e) / 10000;
            mo  = e - 1 - 12 * (e / 14);
            yr  = c - 4715 - (7 + mo) / 10;
            r.year      = yr[11:0];
            r.month     = mo[3:0];
            r.day       = dd[4:0];
            wk          = tod / HOUR_US;
            r.hour      = wk[4:0];
            wk          = (tod % HOUR_US) / MIN_US;
            r.minute    = wk[5:0];
            wk          = tod % MIN_US;
            r.second_us = wk[25:0];
         end
         return r;
      endfunction

      function void note_request(conv_request_type w);
         conv_result_type r;
         r = convert_time(w);
         if (w.op == cgtc_pkg::OP_CAL_TO_GPS) begin
            cal_count++;
         end else begin
            gps_count++;
         end
         if (r.before_epoch) begin
            before_count++;
         end
         expected_times.push_back(r);
      endfunction

      function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(conv_result_type got);
         conv_result_type want;
         if (expected_times.size() == 0) begin
            $error("result word with nothing outstanding");
            errors++;
         end else begin
            want = expected_times.pop_front();
            checked++;
            check_field("out_year", want.year, got.year);
            check_field("out_month", want.month, got.month);
            check_field("out_day", want.day, got.day);
            check_field("out_hour", want.hour, got.hour);
            check_field("out_minute", want.minute, got.minute);
            check_field("out_second_us", want.second_us, got.second_us);
            check_field("out_week", want.week, got.week);
            check_field("out_week_seconds_us", want.week_sec_us, got.week_sec_us);
            check_field("before_epoch", want.before_epoch, got.before_epoch);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [11:0] req_in_year = '0;
   logic [3:0]  req_in_month = '0;
   logic [4:0]  req_in_day = '0;
   logic [4:0]  req_in_hour = '0;
   logic [5:0]  req_in_minute = '0;
   logic [25:0] req_in_second_us = '0;
   logic [12:0] req_in_week = '0;
   logic [39:0] req_in_week_seconds_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic [25:0] rsp_out_second_us;
   logic [12:0] rsp_out_week;
   logic [39:0] rsp_out_week_seconds_us;
   logic        rsp_before_epoch;

   int cycle_count = 0;
   time_conversion_scoreboard conv_board;

   calendar_gps_time_converter_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_operation           (req_operation),
      .req_in_year             (req_in_year),
      .req_in_month            (req_in_month),
      .req_in_day              (req_in_day),
      .req_in_hour             (req_in_hour),
      .req_in_minute           (req_in_minute),
      .req_in_second_us        (req_in_second_us),
      .req_in_week             (req_in_week),
      .req_in_week_seconds_us  (req_in_week_seconds_us),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_out_year            (rsp_out_year),
      .rsp_out_month           (rsp_out_month),
      .rsp_out_day             (rsp_out_day),
      .rsp_out_hour            (rsp_out_hour),
      .rsp_out_minute          (rsp_out_minute),
      .rsp_out_second_us       (rsp_out_second_us),
      .rsp_out_week            (rsp_out_week),
      .rsp_out_week_seconds_us (rsp_out_week_seconds_us),
      .rsp_before_epoch        (rsp_before_epoch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   // fields that the chosen direction ignores carry random bits
   function automatic conv_request_type noise_word();
      conv_request_type w;
      longint unsigned hi;
      hi = {$urandom(), $urandom()};
      w.op          = cgtc_pkg::op_type'($urandom_range(0, 1));
      w.year        = 12'($urandom());
      w.month       = 4'($urandom());
      w.day         = 5'($urandom());
      w.hour        = 5'($urandom());
      w.minute      = 6'($urandom());
      w.second_us   = 26'($urandom());
      w.week        = 13'($urandom());
      w.week_sec_us = hi[39:0];
      return w;
   endfunction

   function automatic conv_request_type cal_word(int y, int mo, int d, int h, int mi, int s);
      conv_request_type w;
      w = noise_word();
      w.op        = cgtc_pkg::OP_CAL_TO_GPS;
      w.year      = 12'(y);
      w.month     = 4'(mo);
      w.day       = 5'(d);
      w.hour      = 5'(h);
      w.minute    = 6'(mi);
      w.second_us = 26'(s);
      return w;
   endfunction

   function automatic conv_request_type gps_word(int wk, longint unsigned sow);
      conv_request_type w;
      w = noise_word();
      w.op          = cgtc_pkg::OP_GPS_TO_CAL;
      w.week        = 13'(wk);
      w.week_sec_us = sow[39:0];
      return w;
   endfunction

   function automatic conv_request_type random_word();
      int r;
      longint unsigned sow;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return cal_word($urandom_range(1975, 2099), $urandom_range(1, 12),
                         $urandom_range(1, 31), $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59999999));
      end else if (r < 80) begin
         sow = {$urandom(), $urandom()};
         sow = sow % 64'd604800000000;
         return gps_word($urandom_range(0, 6500), sow);
      end else begin
         return noise_word();
      end
   endfunction

   task automatic send_word(conv_request_type w);
      req_valid              <= 1'b1;
      req_operation          <= w.op;
      req_in_year            <= w.year;
      req_in_month           <= w.month;
      req_in_day             <= w.day;
      req_in_hour            <= w.hour;
      req_in_minute          <= w.minute;
      req_in_second_us       <= w.second_us;
      req_in_week            <= w.week;
      req_in_week_seconds_us <= w.week_sec_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_and_idle(conv_request_type w, bit no_idle);
      int gap;
      send_word(w);
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      conv_request_type seen_req;
      conv_result_type  seen_rsp;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_req.op          = cgtc_pkg::op_type'(req_operation);
            seen_req.year        = req_in_year;
            seen_req.month       = req_in_month;
            seen_req.day         = req_in_day;
            seen_req.hour        = req_in_hour;
            seen_req.minute      = req_in_minute;
            seen_req.second_us   = req_in_second_us;
            seen_req.week        = req_in_week;
            seen_req.week_sec_us = req_in_week_seconds_us;
            conv_board.note_request(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            seen_rsp.year         = rsp_out_year;
            seen_rsp.month        = rsp_out_month;
            seen_rsp.day          = rsp_out_day;
            seen_rsp.hour         = rsp_out_hour;
            seen_rsp.minute       = rsp_out_minute;
            seen_rsp.second_us    = rsp_out_second_us;
            seen_rsp.week         = rsp_out_week;
            seen_rsp.week_sec_us  = rsp_out_week_seconds_us;
            seen_rsp.before_epoch = rsp_before_epoch;
            conv_board.check_result(seen_rsp);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side back-pressure, with long stretches of no stall
   initial begin
      int run;
      int stall;
      repeat (6) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
         repeat (run) @(posedge clock);
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      conv_request_type directed_words[$];
      conv_board = new;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed_words.push_back(cal_word(1980, 1, 6, 0, 0, 0));
      directed_words.push_back(cal_word(1980, 1, 5, 23, 59, 59999999));
      directed_words.push_back(cal_word(0, 0, 0, 0, 0, 0));
      directed_words.push_back(cal_word(4095, 15, 31, 31, 63, 67108863));
      directed_words.push_back(cal_word(2099, 12, 31, 23, 59, 59999999));
      directed_words.push_back(cal_word(2000, 2, 29, 12, 0, 0));
      directed_words.push_back(cal_word(2021, 3, 0, 0, 0, 0));
      directed_words.push_back(cal_word(2021, 2, 31, 0, 0, 0));
      directed_words.push_back(cal_word(2021, 0, 15, 0, 0, 0));
      directed_words.push_back(cal_word(2021, 13, 1, 0, 0, 0));
      directed_words.push_back(cal_word(2021, 15, 1, 0, 0, 0));
      directed_words.push_back(cal_word(2021, 6, 30, 31, 63, 67108863));
      directed_words.push_back(cal_word(2200, 1, 1, 0, 0, 0));
      directed_words.push_back(cal_word(1980, 2, 1, 0, 0, 0));
      directed_words.push_back(cal_word(1980, 3, 1, 0, 0, 0));
      directed_words.push_back(gps_word(0, 64'd0));
      directed_words.push_back(gps_word(8191, 64'hFF_FFFF_FFFF));
      directed_words.push_back(gps_word(0, 64'd604800000000));
      directed_words.push_back(gps_word(0, 64'd604799999999));
      directed_words.push_back(gps_word(1042, 64'd518400000000));
      directed_words.push_back(gps_word(6500, 64'd0));
      directed_words.push_back(gps_word(1, 64'd86399999999));
      directed_words.push_back(gps_word(1055, 64'd86400000000));
      foreach (directed_words[i]) begin
         send_and_idle(directed_words[i], 1'b0);
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         send_and_idle(random_word(), ((i / 100) % 3) == 2);
      end
      req_valid <= 1'b0;

      while (conv_board.expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (conv_board.expected_times.size() != 0) begin
         $error("%0d result words never arrived", conv_board.expected_times.size());
         conv_board.errors++;
      end

      $display("converted %0d words: %0d calendar to gps, %0d gps to calendar",
               conv_board.checked, conv_board.cal_count, conv_board.gps_count);
      $display("%0d dates before the gps epoch, %0d mismatches",
               conv_board.before_count, conv_board.errors);
      if (conv_board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
